>>> hdl/assert_macros.svh
// assertion macros shared by the filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define PRWF_ASSERT_IMP(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("replay filter check failed");

// property that must hold in the cycle after its trigger
`define PRWF_ASSERT_NXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("replay filter check failed");

`endif

>>> hdl/prwf_pkg.sv
// types, constants and codes of the replay window filter
package prwf_pkg;

    localparam int WINDOW_ENTRIES = 5;
    localparam int DECODER_SLOTS  = 4;

    localparam int OPCODE_W  = 2;
    localparam int SLOT_W    = 2;
    localparam int STAMP_W   = 64;
    localparam int LEN_W     = 16;
    localparam int VERDICT_W = 3;
    localparam int ENTRY_W   = 3;
    localparam int DSTAMP_W  = 29;
    localparam int IDX_W     = (WINDOW_ENTRIES > 1) ? $clog2(WINDOW_ENTRIES) : 1;

    localparam logic [LEN_W-1:0] DATA_MIN_LEN = LEN_W'(4 + 16);
    localparam logic [LEN_W-1:0] CTRL_MIN_LEN = LEN_W'(9 + 16 + 1 + 32 + 24 + 32 + 24 + 8);

    typedef enum logic [OPCODE_W-1:0] {
        OP_DATA  = 2'd0,
        OP_CTRL  = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef enum logic [VERDICT_W-1:0] {
        V_ACCEPT  = 3'd0,
        V_SHORT   = 3'd1,
        V_DUP     = 3'd2,
        V_LATE    = 3'd3,
        V_AUTH    = 3'd4,
        V_CLEARED = 3'd5
    } verdict_t;

    typedef logic [DSTAMP_W-1:0] dstamp_t;
    typedef dstamp_t             win_row_t [WINDOW_ENTRIES];

    // update from the check stage to the window store
    typedef struct packed {
        logic              data_we;
        logic [SLOT_W-1:0] slot;
        logic [IDX_W-1:0]  idx;
        dstamp_t           stamp;
        logic              clear_one;
        logic              clear_pair;
        logic              sender;
    } win_cmd_t;

    // lookup result of one data stamp against its slot
    typedef struct packed {
        logic             dup;
        logic             late;
        logic [IDX_W-1:0] min_idx;
    } win_look_t;

endpackage

>>> hdl/prwf_req_if.sv
// request channel carrying one packet header check
interface prwf_req_if
    import prwf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [SLOT_W-1:0]   key_slot;
    logic [STAMP_W-1:0]  stamp;
    logic [LEN_W-1:0]    packet_length;
    logic                auth_ok;
    logic                sender_key_id;

    modport source (output valid, opcode, key_slot, stamp, packet_length, auth_ok,
                    sender_key_id, input ready);
    modport sink   (input valid, opcode, key_slot, stamp, packet_length, auth_ok,
                    sender_key_id, output ready);
endinterface

>>> hdl/prwf_res_if.sv
// result channel carrying one verdict
interface prwf_res_if
    import prwf_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [ENTRY_W-1:0]   replaced_entry;

    modport source (output valid, verdict, replaced_entry, input ready);
    modport sink   (input valid, verdict, replaced_entry, output ready);
endinterface

>>> hdl/prwf_window.sv
// per-slot windows of data timestamps with duplicate, late and minimum lookup
`include "assert_macros.svh"

module prwf_window
    import prwf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] look_slot,
    input  dstamp_t           look_stamp,
    input  win_cmd_t          cmd,
    output win_look_t         look
);

    win_row_t win_reg  [DECODER_SLOTS];
    win_row_t win_next [DECODER_SLOTS];
    win_row_t row;
    dstamp_t  low;
    logic [IDX_W-1:0] low_idx;
    logic     dup;

    // lookup: duplicate scan and first lowest entry
    always_comb
    begin
        row     = win_reg[look_slot];
        dup     = 1'b0;
        low     = row[0];
        low_idx = '0;
        for (int i = 0; i < WINDOW_ENTRIES; i++)
        begin
            if (row[i] == look_stamp)
                dup = 1'b1;
        end
        for (int i = 1; i < WINDOW_ENTRIES; i++)
        begin
            if (row[i] < low)
            begin
                low     = row[i];
                low_idx = IDX_W'(i);
            end
        end
        look.dup     = dup;
        look.late    = (look_stamp <= low);
        look.min_idx = low_idx;
    end

    // next window contents: slot clears and data overwrite
    always_comb
    begin
        for (int s = 0; s < DECODER_SLOTS; s++)
        begin
            for (int i = 0; i < WINDOW_ENTRIES; i++)
            begin
                win_next[s][i] = win_reg[s][i];
                if ((cmd.clear_one && (cmd.slot == SLOT_W'(s))) ||
                    (cmd.clear_pair && ({1'b0, cmd.sender} == (SLOT_W'(s) >> 1))))
                    win_next[s][i] = '0;
                else if (cmd.data_we && (cmd.slot == SLOT_W'(s)) &&
                         (cmd.idx == IDX_W'(i)))
                    win_next[s][i] = cmd.stamp;
            end
        end
    end

    // window storage, zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DECODER_SLOTS; s++)
                for (int i = 0; i < WINDOW_ENTRIES; i++)
                    win_reg[s][i] <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    `PRWF_ASSERT_NXT(a_data_written, cmd.data_we, win_reg[$past(cmd.slot)][$past(cmd.idx)] == $past(cmd.stamp))
    `PRWF_ASSERT_NXT(a_slot_cleared, cmd.clear_one, win_reg[$past(cmd.slot)][0] == '0)

endmodule

>>> hdl/prwf_control.sv
// last accepted control timestamp and its late check
module prwf_control
    import prwf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [STAMP_W-1:0] stamp,
    input  logic               update,
    output logic               late
);

    logic [STAMP_W-1:0] last_reg;
    logic [STAMP_W-1:0] last_next;

    // late unless strictly above the last control stamp
    always_comb
    begin
        late      = (stamp <= last_reg);
        last_next = update ? stamp : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= '0;
        else
            last_reg <= last_next;
    end

endmodule

>>> hdl/packet_replay_window_filter_top.sv
// top level of the packet replay window filter
//
// usage:
//   packets (sink) takes one header check request per cycle: opcode, key slot,
//   timestamp, length, authentication result and sender key id.
//   results (source) returns one verdict and the replaced window entry for
//   each data, control or clear request; a request with the unused opcode
//   updates nothing and returns no result.
// path: a request passes through the input register, then the check logic
//   into the result register.
// throughput: one request per cycle; the window and control stamp are
//   written at the same edge as the result register, so the next request
//   is checked against the updated state.
// reset: all slot windows and the control stamp are zero, both stages empty.
// stall: while results is not ready the result register holds, the input
//   register holds one more request, and packets.ready drops until the
//   result is taken.
`include "assert_macros.svh"

module packet_replay_window_filter_top
    import prwf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    prwf_req_if.sink    packets,
    prwf_res_if.source  results
);

    // input register
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [OPCODE_W-1:0] s1_opcode_reg;
    logic [SLOT_W-1:0]   s1_slot_reg;
    logic [STAMP_W-1:0]  s1_stamp_reg;
    logic [LEN_W-1:0]    s1_len_reg;
    logic                s1_auth_reg;
    logic                s1_sender_reg;

    // result register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    verdict_t             out_verdict_reg;
    logic [ENTRY_W-1:0]   out_entry_reg;

    logic       in_fire;
    logic       s1_fire;
    logic       s1_known;
    logic       ctrl_late;
    verdict_t   verdict;
    logic [ENTRY_W-1:0] entry;
    logic       commit_ok;
    win_cmd_t   cmd;
    win_look_t  look;

    // handshake
    assign s1_known       = (s1_opcode_reg == OP_DATA) || (s1_opcode_reg == OP_CTRL) ||
                            (s1_opcode_reg == OP_CLEAR);
    assign s1_fire        = s1_valid_reg && (!s1_known || !out_valid_reg || results.ready);
    assign packets.ready  = !s1_valid_reg || s1_fire;
    assign in_fire        = packets.valid && packets.ready;
    assign s1_valid_next  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = (s1_fire && s1_known) ? 1'b1 :
                            (results.ready ? 1'b0 : out_valid_reg);

    prwf_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .look_slot  (s1_slot_reg),
        .look_stamp (s1_stamp_reg[DSTAMP_W-1:0]),
        .cmd        (cmd),
        .look       (look)
    );

    prwf_control u_control (
        .clk    (clk),
        .rst_n  (rst_n),
        .stamp  (s1_stamp_reg),
        .update (s1_fire && (s1_opcode_reg == OP_CTRL) && commit_ok),
        .late   (ctrl_late)
    );

    // verdict in check order per opcode
    always_comb
    begin
        verdict   = V_CLEARED;
        entry     = '0;
        commit_ok = 1'b0;
        case (s1_opcode_reg)
            OP_DATA:
            begin
                if (s1_len_reg < DATA_MIN_LEN)
                    verdict = V_SHORT;
                else if (look.dup)
                    verdict = V_DUP;
                else if (look.late)
                    verdict = V_LATE;
                else if (!s1_auth_reg)
                    verdict = V_AUTH;
                else
                begin
                    verdict   = V_ACCEPT;
                    entry     = ENTRY_W'(look.min_idx);
                    commit_ok = 1'b1;
                end
            end
            OP_CTRL:
            begin
                if (s1_len_reg < CTRL_MIN_LEN)
                    verdict = V_SHORT;
                else if (ctrl_late)
                    verdict = V_LATE;
                else if (!s1_auth_reg)
                    verdict = V_AUTH;
                else
                begin
                    verdict   = V_ACCEPT;
                    commit_ok = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                verdict = V_CLEARED;
            end
            default:
            begin
                verdict = V_CLEARED;
            end
        endcase
    end

    // window update command, only when the request leaves the input register
    always_comb
    begin
        cmd.data_we    = s1_fire && (s1_opcode_reg == OP_DATA) && commit_ok;
        cmd.slot       = s1_slot_reg;
        cmd.idx        = look.min_idx;
        cmd.stamp      = s1_stamp_reg[DSTAMP_W-1:0];
        cmd.clear_one  = s1_fire && (s1_opcode_reg == OP_CLEAR);
        cmd.clear_pair = s1_fire && (s1_opcode_reg == OP_CTRL) && commit_ok;
        cmd.sender     = s1_sender_reg;
    end

    // control state of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_opcode_reg <= packets.opcode;
            s1_slot_reg   <= packets.key_slot;
            s1_stamp_reg  <= packets.stamp;
            s1_len_reg    <= packets.packet_length;
            s1_auth_reg   <= packets.auth_ok;
            s1_sender_reg <= packets.sender_key_id;
        end
        if (s1_fire && s1_known)
        begin
            out_verdict_reg <= verdict;
            out_entry_reg   <= entry;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.verdict        = out_verdict_reg;
    assign results.replaced_entry = out_entry_reg;

    `PRWF_ASSERT_IMP(a_entry_zero, out_valid_reg && (out_verdict_reg != V_ACCEPT), out_entry_reg == '0)
    `PRWF_ASSERT_IMP(a_entry_range, out_valid_reg, out_entry_reg < ENTRY_W'(WINDOW_ENTRIES))
    `PRWF_ASSERT_NXT(a_clear_result, s1_fire && (s1_opcode_reg == OP_CLEAR), out_valid_reg && (out_verdict_reg == V_CLEARED))

endmodule

>>> tb/testbench.sv
// self-checking testbench for the packet replay window filter
`timescale 1ns / 1ps

module testbench;
    import prwf_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int NUM_VERDICTS = 6;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_SLACK  = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 168;

    // one expected verdict with its replaced window entry
    typedef struct packed {
        verdict_t           verdict;
        logic [ENTRY_W-1:0] entry;
    } verdict_rec_t;

    // keeps its own copy of the slot windows and the control stamp
    class replay_verdict_predictor;
        dstamp_t            windows [DECODER_SLOTS][WINDOW_ENTRIES];
        logic [STAMP_W-1:0] ctrl_stamp;
        verdict_rec_t       expected_verdicts [$];
        int                 errors;
        int                 verdict_counts [NUM_VERDICTS];

        function new();
            foreach (windows[s, e])
                windows[s][e] = '0;
            ctrl_stamp = '0;
            errors = 0;
            foreach (verdict_counts[i])
                verdict_counts[i] = 0;
        endfunction

        function void wipe_slot(int slot);
            for (int e = 0; e < WINDOW_ENTRIES; e++)
                windows[slot][e] = '0;
        endfunction

        // work out the verdict of an accepted request and update the windows
        function void note_request(logic [OPCODE_W-1:0] op, logic [SLOT_W-1:0] slot,
                                   logic [STAMP_W-1:0] stamp, logic [LEN_W-1:0] len,
                                   logic auth, logic sender);
            verdict_rec_t rec;
            dstamp_t      ds;
            dstamp_t      low;
            int           low_idx;
            bit           dup;
            rec.verdict = V_ACCEPT;
            rec.entry   = '0;
            if (op == OP_DATA) begin
                ds      = stamp[DSTAMP_W-1:0];
                dup     = 1'b0;
                low     = windows[slot][0];
                low_idx = 0;
                for (int e = 0; e < WINDOW_ENTRIES; e++) begin
                    if (windows[slot][e] == ds)
                        dup = 1'b1;
                    if (windows[slot][e] < low) begin
                        low     = windows[slot][e];
                        low_idx = e;
                    end
                end
                if (len < DATA_MIN_LEN)
                    rec.verdict = V_SHORT;
                else if (dup)
                    rec.verdict = V_DUP;
                else if (ds <= low)
                    rec.verdict = V_LATE;
                else if (!auth)
                    rec.verdict = V_AUTH;
                else begin
                    windows[slot][low_idx] = ds;
                    rec.entry = ENTRY_W'(low_idx);
                end
            end
            else if (op == OP_CTRL) begin
                if (len < CTRL_MIN_LEN)
                    rec.verdict = V_SHORT;
                else if (stamp <= ctrl_stamp)
                    rec.verdict = V_LATE;
                else if (!auth)
                    rec.verdict = V_AUTH;
                else begin
                    ctrl_stamp = stamp;
                    wipe_slot({sender, 1'b0});
                    wipe_slot({sender, 1'b1});
                end
            end
            else if (op == OP_CLEAR) begin
                wipe_slot(slot);
                rec.verdict = V_CLEARED;
            end
            else
                return;
            expected_verdicts.push_back(rec);
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(logic [VERDICT_W-1:0] verdict, logic [ENTRY_W-1:0] entry);
            verdict_rec_t exp_rec;
            if (expected_verdicts.size() == 0) begin
                $error("result with nothing expected: verdict %0d, replaced_entry %0d",
                       verdict, entry);
                errors++;
                return;
            end
            exp_rec = expected_verdicts.pop_front();
            verdict_counts[exp_rec.verdict]++;
            if (verdict !== exp_rec.verdict) begin
                $error("verdict mismatch: expected %0d, actual %0d", exp_rec.verdict, verdict);
                errors++;
            end
            if (entry !== exp_rec.entry) begin
                $error("replaced_entry mismatch: expected %0d, actual %0d",
                       exp_rec.entry, entry);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   sender_idle_pct = 0;
    int   receiver_stall_pct = 0;
    int   result_requests = 0;
    int   ignored_requests = 0;

    replay_verdict_predictor predictor = new();

    prwf_req_if req_ch ();
    prwf_res_if res_ch ();

    packet_replay_window_filter_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .packets (req_ch.sink),
        .results (res_ch.source)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAIL packet_replay_window_filter_top");
        $finish;
    end

    // result side: random stalls, sample at the falling edge, check at the rising edge
    initial
    begin
        logic                 got;
        logic [VERDICT_W-1:0] got_verdict;
        logic [ENTRY_W-1:0]   got_entry;
        got = 1'b0;
        got_verdict = '0;
        got_entry = '0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (got)
                predictor.check_result(got_verdict, got_entry);
            res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
            @(negedge clk);
            got = res_ch.valid && res_ch.ready;
            got_verdict = res_ch.verdict;
            got_entry = res_ch.replaced_entry;
        end
    end

    // present one request, with random idle cycles first, until it is taken
    task automatic send_request(logic [OPCODE_W-1:0] op, logic [SLOT_W-1:0] slot,
                                logic [STAMP_W-1:0] stamp, logic [LEN_W-1:0] len,
                                logic auth, logic sender);
        logic taken;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= op;
        req_ch.key_slot      <= slot;
        req_ch.stamp         <= stamp;
        req_ch.packet_length <= len;
        req_ch.auth_ok       <= auth;
        req_ch.sender_key_id <= sender;
        do
        begin
            @(negedge clk);
            taken = req_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        predictor.note_request(op, slot, stamp, len, auth, sender);
        if (op == OP_UNUSED)
            ignored_requests++;
        else
            result_requests++;
    endtask

    // hold off the sender until every expected verdict has arrived
    task automatic pause_until_drained();
        req_ch.valid <= 1'b0;
        while (predictor.expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // mostly well-formed stamps: fresh, duplicate or late against the predicted state
    task automatic send_random_request();
        int                  pick;
        logic [OPCODE_W-1:0] op;
        logic [SLOT_W-1:0]   slot;
        logic [STAMP_W-1:0]  stamp;
        logic [LEN_W-1:0]    len;
        logic                auth;
        logic                sender;
        dstamp_t             lo;
        dstamp_t             hi;
        dstamp_t             ds;
        pick   = $urandom_range(99);
        slot   = SLOT_W'($urandom_range(DECODER_SLOTS - 1));
        stamp  = {$urandom, $urandom};
        len    = LEN_W'($urandom);
        auth   = ($urandom_range(99) < 88);
        sender = 1'($urandom_range(1));
        if (pick < 70)
            op = OP_DATA;
        else if (pick < 82)
            op = OP_CTRL;
        else if (pick < 92)
            op = OP_CLEAR;
        else
            op = OP_UNUSED;

        if (op == OP_DATA)
        begin
            lo = predictor.windows[slot][0];
            hi = predictor.windows[slot][0];
            for (int e = 1; e < WINDOW_ENTRIES; e++)
            begin
                if (predictor.windows[slot][e] < lo)
                    lo = predictor.windows[slot][e];
                if (predictor.windows[slot][e] > hi)
                    hi = predictor.windows[slot][e];
            end
            pick = $urandom_range(99);
            if (pick < 50)
                ds = hi + DSTAMP_W'($urandom_range(1, 6));
            else if (pick < 65)
                ds = predictor.windows[slot][$urandom_range(WINDOW_ENTRIES - 1)];
            else if (pick < 80)
                ds = DSTAMP_W'($urandom_range(lo, 0));
            else
                ds = DSTAMP_W'($urandom);
            stamp[DSTAMP_W-1:0] = ds;
            if ($urandom_range(99) < 10)
                len = LEN_W'($urandom_range(DATA_MIN_LEN - 1, 0));
            else
                len = LEN_W'($urandom_range(DATA_MIN_LEN, 16'hFFFF));
        end
        else if (op == OP_CTRL)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                stamp = predictor.ctrl_stamp + STAMP_W'($urandom_range(1, 4));
            else if (pick < 80)
                stamp = (predictor.ctrl_stamp >= 2) ?
                        predictor.ctrl_stamp - STAMP_W'($urandom_range(2, 0)) :
                        predictor.ctrl_stamp;
            if ($urandom_range(99) < 15)
                len = LEN_W'($urandom_range(CTRL_MIN_LEN - 1, 0));
            else
                len = LEN_W'($urandom_range(CTRL_MIN_LEN, 16'hFFFF));
        end
        send_request(op, slot, stamp, len, auth, sender);
    endtask

    // random requests under one idling mix, then a full drain
    task automatic run_phase(int idle_pct, int stall_pct);
        int start_count;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start_count        = result_requests;
        while (result_requests - start_count < PHASE_ITEMS)
            send_random_request();
        pause_until_drained();
    endtask

    // main sequence
    initial
    begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.opcode        = OP_DATA;
        req_ch.key_slot      = '0;
        req_ch.stamp         = '0;
        req_ch.packet_length = '0;
        req_ch.auth_ok       = 1'b0;
        req_ch.sender_key_id = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero stamp on a fresh slot, short lengths, auth failure, first accept
        send_request(OP_DATA, 2'd0, 64'd0, DATA_MIN_LEN, 1'b1, 1'b0);
        send_request(OP_DATA, 2'd0, 64'd5, DATA_MIN_LEN - 16'd1, 1'b1, 1'b0);
        send_request(OP_DATA, 2'd0, 64'd5, 16'd0, 1'b1, 1'b1);
        send_request(OP_DATA, 2'd0, 64'd5, DATA_MIN_LEN, 1'b0, 1'b0);
        send_request(OP_DATA, 2'd0, 64'd5, 16'hFFFF, 1'b1, 1'b1);
        send_request(OP_DATA, 2'd0, 64'd5, DATA_MIN_LEN, 1'b1, 1'b0);
        // all-ones stamp keeps only its low bits
        send_request(OP_DATA, 2'd0, '1, DATA_MIN_LEN, 1'b1, 1'b0);
        send_request(OP_DATA, 2'd0, 64'd6, DATA_MIN_LEN, 1'b1, 1'b0);
        send_request(OP_DATA, 2'd0, 64'd7, DATA_MIN_LEN, 1'b1, 1'b0);
        send_request(OP_DATA, 2'd0, 64'd8, DATA_MIN_LEN, 1'b1, 1'b0);
        // late against the window minimum, then a replacement of that minimum
        send_request(OP_DATA, 2'd0, 64'd4, DATA_MIN_LEN, 1'b1, 1'b0);
        send_request(OP_DATA, 2'd0, 64'd9, DATA_MIN_LEN, 1'b1, 1'b1);
        send_request(OP_DATA, 2'd1, 64'd3, DATA_MIN_LEN, 1'b1, 1'b0);
        // control checks in order, then an accept that wipes slots of key id zero
        send_request(OP_CTRL, 2'd0, 64'd10, CTRL_MIN_LEN - 16'd1, 1'b1, 1'b0);
        send_request(OP_CTRL, 2'd0, 64'd0, CTRL_MIN_LEN, 1'b1, 1'b0);
        send_request(OP_CTRL, 2'd0, 64'd10, CTRL_MIN_LEN, 1'b0, 1'b0);
        send_request(OP_CTRL, 2'd3, 64'd10, 16'hFFFF, 1'b1, 1'b0);
        send_request(OP_DATA, 2'd0, 64'd0, DATA_MIN_LEN, 1'b1, 1'b0);
        send_request(OP_DATA, 2'd2, 64'd7, DATA_MIN_LEN, 1'b1, 1'b0);
        send_request(OP_CTRL, 2'd0, 64'd11, CTRL_MIN_LEN, 1'b1, 1'b1);
        send_request(OP_DATA, 2'd2, 64'd7, DATA_MIN_LEN, 1'b1, 1'b1);
        // clears and the unused opcode
        send_request(OP_CLEAR, 2'd2, '1, 16'hFFFF, 1'b0, 1'b1);
        send_request(OP_CLEAR, 2'd3, 64'd0, 16'd0, 1'b1, 1'b0);
        send_request(OP_UNUSED, 2'd1, '1, 16'hFFFF, 1'b1, 1'b1);
        send_request(OP_DATA, 2'd3, 64'd1, DATA_MIN_LEN, 1'b1, 1'b0);
        pause_until_drained();

        run_phase(0, 0);
        run_phase(46, 0);
        run_phase(0, 46);
        run_phase(29, 29);

        // largest control stamp last, since nothing can follow it
        send_request(OP_CTRL, 2'd1, '1, CTRL_MIN_LEN, 1'b1, 1'($urandom_range(1)));
        send_request(OP_CTRL, 2'd2, '1, 16'hFFFF, 1'b1, 1'b0);
        pause_until_drained();

        $display("%0d verdicts checked: %0d accepted, %0d short, %0d duplicate, %0d late",
                 result_requests, predictor.verdict_counts[V_ACCEPT],
                 predictor.verdict_counts[V_SHORT], predictor.verdict_counts[V_DUP],
                 predictor.verdict_counts[V_LATE]);
        $display("%0d auth failed, %0d cleared, %0d unused-opcode requests, four idling mixes",
                 predictor.verdict_counts[V_AUTH], predictor.verdict_counts[V_CLEARED],
                 ignored_requests);
        if (predictor.errors == 0 && predictor.expected_verdicts.size() == 0)
            $display("PASS packet_replay_window_filter_top");
        else
            $display("FAIL packet_replay_window_filter_top");
        $finish;
    end

endmodule
